/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker of the allocator.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_IMP(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("allocator check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("allocator check failed: next-cycle implication");

`endif

/* sv/ffba_pkg.sv */
// Types and codes shared by the first-fit block allocator files.
// No dependencies.
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int ADDR_W = 16;
	localparam int ALU_W  = 17;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2,
		CMD_RSVD    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADADDR = 2'd2
	} status_t;

	// One block table entry: header offset, payload size, free flag.
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] bytes;
		logic              free;
	} ent_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             cout;
	} alu_rsp_t;

endpackage

/* sv/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: sequencer, block table RAM, shared ALU.
// Depends on ffba_pkg, ffba_ram and ffba_alu.
`timescale 1ns / 1ps

// First-fit heap allocator over an address-ordered block table held in one RAM.
// Each command takes one transaction and returns one result transaction; the
// block works on a single command at a time and holds in_stall high until the
// result has been taken. The cost is set by walks over the table RAM, one entry
// per cycle through its single read port, with one add/compare unit shared by
// the arithmetic steps. Allocate and free scan the table up to the hit and,
// if an entry is split off or merged away, shift the entries behind it; a
// reallocate that keeps its block needs one scan, and a moving reallocate adds
// an allocate, a second scan and a free. After reset the S_INIT state
// initializes table entry zero before the first command.

module first_fit_block_allocator_top import ffba_pkg::*; #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] request_bytes,
	input  logic [15:0] payload_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] result_address,
	output logic        moved,
	output logic [15:0] copy_bytes,
	output logic [15:0] allocated_total
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [ALU_W-1:0]  HDR   = ALU_W'(HEADER_BYTES);
	localparam logic [ADDR_W-1:0] HDR16 = ADDR_W'(HEADER_BYTES);
	localparam logic [ADDR_W-1:0] INIT_BYTES = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_PREP_T, S_PREP_S, S_SCAN_GO, S_SCAN, S_KEEP,
		S_AL_NS, S_AL_NB, S_AL_SUM, S_AL_RES, S_SHUP, S_SHUP_LAST, S_W_NEW, S_W_CUR,
		S_FR_RD, S_FR_NX, S_MERGE, S_FR_WR, S_SHDN, S_SHDN_LAST, S_FR_END, S_OUT
	} state_t;

	typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_REALLOC} op_t;
	typedef enum logic [1:0] {RP_FIRST, RP_ALLOC, RP_REFIND} rph_t;

	state_t state_q;
	op_t    op_q;
	rph_t   re_q;
	logic   fit_q;

	logic [15:0]      size_q, addr_q, tgt_q, diff_q, nstart_q, nbytes_q;
	logic [15:0]      old_q, acc_q, sum_q, result_q, copy_q;
	logic [ALU_W-1:0] sizeh_q;
	logic             tgt_ok_q, split_q, p_q, n_q, wpend_q, moved_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    idx_q, sp_q, wp_q;
	logic [1:0]       gap_q, step_q;
	ent_t             cur_q, prev_q, nxt_q;
	status_t          status_q;

	// RAM and ALU connections
	logic          ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	ent_t          ram_wdata, rd;
	logic [$bits(ent_t)-1:0] ram_rdata;
	alu_req_t      alu_req;
	alu_rsp_t      alu_rsp;

	ffba_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ffba_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign rd = ent_t'(ram_rdata);

	logic [CW-1:0] idx_nx;
	logic          scan_hit, alu_zero;
	logic [IW-1:0] dst_w;
	logic [1:0]    gap_w;
	logic [CW-1:0] src_w;

	assign idx_nx   = CW'(idx_q) + CW'(1);
	assign alu_zero = (alu_rsp.res == '0);
	assign scan_hit = fit_q ? (rd.free && alu_rsp.cout) : (!rd.free && tgt_ok_q && alu_zero);
	assign dst_w    = p_q ? (idx_q - IW'(1)) : idx_q;
	assign gap_w    = {1'b0, p_q} + {1'b0, n_q};
	assign src_w    = CW'(dst_w) + CW'(gap_w) + CW'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = rd;
		ram_raddr = '0;
		alu_req   = '0;
		case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = '{start: '0, bytes: INIT_BYTES, free: 1'b1};
			end
			S_PREP_T: begin
				alu_req = '{a: {1'b0, addr_q}, b: HDR, sub: 1'b1};
			end
			S_PREP_S: begin
				alu_req = '{a: {1'b0, size_q}, b: HDR, sub: 1'b0};
			end
			S_SCAN: begin
				ram_raddr = idx_q + IW'(1);
				if (fit_q) begin
					alu_req = '{a: {1'b0, rd.bytes}, b: {1'b0, size_q}, sub: 1'b1};
				end else begin
					alu_req = '{a: {1'b0, rd.start}, b: {1'b0, tgt_q}, sub: 1'b1};
				end
			end
			S_KEEP: begin
				alu_req = '{a: {1'b0, cur_q.bytes}, b: {1'b0, size_q}, sub: 1'b1};
			end
			S_AL_NS: begin
				alu_req = '{a: {1'b0, cur_q.start}, b: sizeh_q, sub: 1'b0};
			end
			S_AL_NB: begin
				alu_req = '{a: {1'b0, diff_q}, b: HDR, sub: 1'b1};
			end
			S_AL_SUM: begin
				alu_req = '{a: {1'b0, sum_q}, b: {1'b0, (split_q ? size_q : cur_q.bytes)},
					sub: 1'b0};
			end
			S_AL_RES: begin
				alu_req = '{a: {1'b0, cur_q.start}, b: HDR, sub: 1'b0};
			end
			S_SHUP, S_SHDN: begin
				ram_raddr = sp_q;
				ram_we    = wpend_q;
			end
			S_SHUP_LAST, S_SHDN_LAST: begin
				ram_we = 1'b1;
			end
			S_W_NEW: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q + IW'(1);
				ram_wdata = '{start: nstart_q, bytes: nbytes_q, free: 1'b1};
			end
			S_W_CUR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = '{start: cur_q.start, bytes: (split_q ? size_q : cur_q.bytes),
					free: 1'b0};
			end
			S_FR_RD: begin
				ram_raddr = idx_q + IW'(1);
				alu_req   = '{a: {1'b0, sum_q}, b: {1'b0, cur_q.bytes}, sub: 1'b1};
			end
			S_MERGE: begin
				alu_req.a   = {1'b0, acc_q};
				alu_req.sub = 1'b0;
				case (step_q)
					2'd0:    alu_req.b = p_q ? {1'b0, prev_q.bytes} : '0;
					2'd1:    alu_req.b = p_q ? HDR : '0;
					2'd2:    alu_req.b = n_q ? {1'b0, nxt_q.bytes} : '0;
					default: alu_req.b = n_q ? HDR : '0;
				endcase
			end
			S_FR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = dst_w;
				ram_wdata = '{start: (p_q ? prev_q.start : cur_q.start), bytes: acc_q,
					free: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			count_q  <= CW'(1);
			sum_q    <= '0;
			wpend_q  <= 1'b0;
			status_q <= ST_OK;
			result_q <= '0;
			moved_q  <= 1'b0;
			copy_q   <= '0;
			op_q     <= OP_ALLOC;
			re_q     <= RP_FIRST;
			fit_q    <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					count_q <= CW'(1);
					sum_q   <= '0;
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						size_q   <= request_bytes;
						addr_q   <= payload_address;
						status_q <= ST_OK;
						result_q <= '0;
						moved_q  <= 1'b0;
						copy_q   <= '0;
						re_q     <= RP_FIRST;
						state_q  <= S_PREP_T;
						case (cmd_t'(command))
							CMD_ALLOC: begin
								op_q  <= OP_ALLOC;
								fit_q <= 1'b1;
							end
							CMD_FREE: begin
								op_q  <= OP_FREE;
								fit_q <= 1'b0;
							end
							CMD_REALLOC: begin
								// zero is never a payload offset: treat as allocate
								op_q  <= (payload_address == '0) ? OP_ALLOC : OP_REALLOC;
								fit_q <= (payload_address == '0);
							end
							default: begin
								status_q <= ST_BADADDR;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_PREP_T: begin
					tgt_q    <= alu_rsp.res[15:0];
					tgt_ok_q <= alu_rsp.cout;
					state_q  <= S_PREP_S;
				end
				S_PREP_S: begin
					sizeh_q <= alu_rsp.res;
					state_q <= S_SCAN_GO;
				end
				S_SCAN_GO: begin
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_hit) begin
						cur_q  <= rd;
						diff_q <= alu_rsp.res[15:0];
						if (fit_q) begin
							state_q <= S_AL_NS;
						end else if (op_q == OP_FREE || re_q == RP_REFIND) begin
							state_q <= S_FR_RD;
						end else begin
							state_q <= S_KEEP;
						end
					end else begin
						prev_q <= rd;
						if (idx_nx == count_q) begin
							if (fit_q) begin
								status_q <= ST_NOFIT;
								result_q <= '0;
								moved_q  <= 1'b0;
								copy_q   <= '0;
							end else if (re_q != RP_REFIND) begin
								status_q <= ST_BADADDR;
							end
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				S_KEEP: begin
					if (alu_rsp.cout) begin
						result_q <= addr_q;
						state_q  <= S_OUT;
					end else begin
						old_q   <= cur_q.bytes;
						re_q    <= RP_ALLOC;
						fit_q   <= 1'b1;
						state_q <= S_SCAN_GO;
					end
				end
				S_AL_NS: begin
					nstart_q <= alu_rsp.res[15:0];
					split_q  <= (diff_q > HDR16) && (count_q < MAXC);
					state_q  <= S_AL_NB;
				end
				S_AL_NB: begin
					nbytes_q <= alu_rsp.res[15:0];
					state_q  <= S_AL_SUM;
				end
				S_AL_SUM: begin
					sum_q   <= alu_rsp.res[15:0];
					state_q <= S_AL_RES;
				end
				S_AL_RES: begin
					result_q <= alu_rsp.res[15:0];
					if (op_q == OP_REALLOC) begin
						moved_q <= 1'b1;
						copy_q  <= old_q;
					end
					wpend_q <= 1'b0;
					sp_q    <= IW'(count_q - CW'(1));
					if (!split_q) begin
						state_q <= S_W_CUR;
					end else if (idx_nx < count_q) begin
						state_q <= S_SHUP;
					end else begin
						state_q <= S_W_NEW;
					end
				end
				S_SHUP: begin
					// read one entry, write the previous one a slot higher
					wpend_q <= 1'b1;
					wp_q    <= sp_q + IW'(1);
					if (sp_q == idx_q + IW'(1)) begin
						state_q <= S_SHUP_LAST;
					end else begin
						sp_q <= sp_q - IW'(1);
					end
				end
				S_SHUP_LAST: begin
					wpend_q <= 1'b0;
					state_q <= S_W_NEW;
				end
				S_W_NEW: begin
					count_q <= count_q + CW'(1);
					state_q <= S_W_CUR;
				end
				S_W_CUR: begin
					if (op_q == OP_REALLOC) begin
						re_q    <= RP_REFIND;
						fit_q   <= 1'b0;
						state_q <= S_SCAN_GO;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_FR_RD: begin
					sum_q   <= alu_rsp.res[15:0];
					state_q <= S_FR_NX;
				end
				S_FR_NX: begin
					nxt_q   <= rd;
					n_q     <= (idx_nx < count_q) && rd.free;
					p_q     <= (idx_q != '0) && prev_q.free;
					acc_q   <= cur_q.bytes;
					step_q  <= '0;
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					acc_q  <= alu_rsp.res[15:0];
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= S_FR_WR;
					end
				end
				S_FR_WR: begin
					gap_q   <= gap_w;
					sp_q    <= IW'(src_w);
					wpend_q <= 1'b0;
					if (gap_w != '0 && src_w < count_q) begin
						state_q <= S_SHDN;
					end else begin
						state_q <= S_FR_END;
					end
				end
				S_SHDN: begin
					// read one entry, write the previous one down by the gap
					wpend_q <= 1'b1;
					wp_q    <= sp_q - IW'(gap_q);
					if (CW'(sp_q) + CW'(1) == count_q) begin
						state_q <= S_SHDN_LAST;
					end else begin
						sp_q <= sp_q + IW'(1);
					end
				end
				S_SHDN_LAST: begin
					wpend_q <= 1'b0;
					state_q <= S_FR_END;
				end
				S_FR_END: begin
					count_q <= count_q - CW'(gap_q);
					if (op_q == OP_FREE) begin
						result_q <= addr_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = (state_q == S_OUT);
	assign status          = status_q;
	assign result_address  = result_q;
	assign moved           = moved_q;
	assign copy_bytes      = copy_q;
	assign allocated_total = sum_q;

endmodule

/* sv/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int unsigned WIDTH = 33,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/ffba_alu.sv */
// Shared add/subtract unit of the allocator sequencer.
// Depends on ffba_pkg for the request and response structs.
`timescale 1ns / 1ps

module ffba_alu import ffba_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W:0] sum;

	// Subtract as a + ~b + 1; carry out set means a >= b.
	assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{ALU_W{1'b0}}, req.sub};
	assign rsp.res  = sum[ALU_W-1:0];
	assign rsp.cout = sum[ALU_W];

endmodule

/* sv/ffba_checker.sv */
// Port-level checker for the first-fit block allocator, bound to its top level.
// Depends on ffba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffba_checker import ffba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [15:0] result_address,
	input logic        moved,
	input logic [15:0] copy_bytes,
	input logic [15:0] allocated_total
);

	// a stalled result transaction holds
	`FFBA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_address) && $stable(moved) && $stable(copy_bytes) && $stable(allocated_total))

	// failed commands report no address and no move
	`FFBA_ASSERT_IMP(a_err_clean, out_valid && status != ST_OK, result_address == 16'd0 && !moved && copy_bytes == 16'd0)

	// a move is only reported with a granted address
	`FFBA_ASSERT_IMP(a_moved_ok, out_valid && moved, status == ST_OK && result_address != 16'd0)

	// one command at a time: busy right after a transaction is taken
	`FFBA_ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall)

	// no new command while a result waits
	`FFBA_ASSERT_IMP(a_no_overlap, out_valid, in_stall)

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);
